/* rtl/core/lbd_pkg.sv */
package lbd_pkg;

    localparam int unsigned WIDTH_REG_BITS  = 12;
    localparam int unsigned HEIGHT_REG_BITS = 13;
    localparam int unsigned CFG_DATA_BITS   = 13;
    localparam int unsigned ROW_BITS        = 13;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam int unsigned OUTQ_DEPTH    = 4;
    localparam int unsigned OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } t_mode;

    typedef struct packed {
        logic eval;
        logic top_ok;
        logic wr;
        logic fin;
        logic x_first;
        logic x_last;
        logic fwd;
    } t_cmd;

endpackage

/* rtl/core/lbd_ram.sv */
module lbd_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lbd_seq.sv */
module lbd_seq #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned LABEL_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [lbd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_mode,
    input  logic [LABEL_BITS-1:0]               i_label,
    output logic                                o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_rd_addr,
    output logic                                o_s1_valid,
    output lbd_pkg::t_cmd                       o_s1_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_s1_addr,
    output logic [LABEL_BITS-1:0]               o_s1_label
);

    import lbd_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    logic [WIDTH_REG_BITS-1:0]  r_image_width;
    logic [HEIGHT_REG_BITS-1:0] r_image_height;
    logic [CW-1:0]              r_in_col;
    logic [CW-1:0]              n_in_col;
    logic [ROW_BITS-1:0]        r_in_row;
    logic [ROW_BITS-1:0]        n_in_row;
    logic                       r_s1_valid;
    t_cmd                       r_s1_cmd;
    t_cmd                       n_s1_cmd;
    logic [AW-1:0]              r_s1_addr;
    logic [LABEL_BITS-1:0]      r_s1_label;

    logic [31:0]           width_ext;
    logic [CW-1:0]         w_eff;
    logic [ROW_BITS-1:0]   h_eff;
    logic [CW-1:0]         col_inc;
    logic                  draining;
    logic                  col_in;
    logic                  go;

    always_comb begin
        width_ext = 32'(r_image_width);
        if (r_image_width == '0) begin
            w_eff = CW'(1);
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = width_ext[CW-1:0];
        end
        h_eff = (r_image_height == '0) ? ROW_BITS'(1) : ROW_BITS'(r_image_height);
    end

    assign draining = (r_in_row >= h_eff);
    assign col_in   = (r_in_col < w_eff);
    assign go       = i_accept && (draining || (i_mode == MODE_PIXEL));
    assign col_inc  = r_in_col + CW'(1);

    assign o_rd_en   = go;
    assign o_rd_addr = r_in_col[AW-1:0];

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (go) begin
            if (col_in) begin
                n_in_col = col_inc;
                if (!draining && (col_inc >= w_eff)) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_BITS'(1);
                end
            end else begin
                n_in_col = '0;
                n_in_row = '0;
            end
        end

        n_s1_cmd.eval    = col_in && (r_in_row != '0);
        n_s1_cmd.top_ok  = (r_in_row >= ROW_BITS'(2));
        n_s1_cmd.wr      = col_in && !draining;
        n_s1_cmd.fin     = !col_in;
        n_s1_cmd.x_first = (r_in_col == '0);
        n_s1_cmd.x_last  = (col_inc == w_eff);
        n_s1_cmd.fwd     = r_s1_valid && r_s1_cmd.wr && (r_s1_addr == r_in_col[AW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_s1_valid     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[WIDTH_REG_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_REG_BITS-1:0];
                default: r_image_width <= r_image_width;
            endcase
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_s1_valid <= go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_cmd   <= n_s1_cmd;
            r_s1_addr  <= r_in_col[AW-1:0];
            r_s1_label <= draining ? '0 : i_label;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_cmd   = r_s1_cmd;
    assign o_s1_addr  = r_s1_addr;
    assign o_s1_label = r_s1_label;

endmodule

/* rtl/core/lbd_eval.sv */
module lbd_eval #(
    parameter int unsigned LABEL_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic                  i_valid,
    input  lbd_pkg::t_cmd         i_cmd,
    input  logic [LABEL_BITS-1:0] i_label,
    input  logic [LABEL_BITS-1:0] i_center_rdata,
    input  logic [LABEL_BITS-1:0] i_above_rdata,
    output logic                  o_we,
    output logic [LABEL_BITS-1:0] o_center_wdata,
    output logic [LABEL_BITS-1:0] o_above_wdata,
    output logic                  o_push,
    output logic                  o_border,
    output logic [LABEL_BITS-1:0] o_pixel_label,
    output logic                  o_last
);

    import lbd_pkg::*;

    logic                  r_hold_valid;
    logic [LABEL_BITS-1:0] r_hold_me;
    logic [LABEL_BITS-1:0] r_hold_left;
    logic [LABEL_BITS-1:0] r_hold_top;
    logic [LABEL_BITS-1:0] r_hold_bot;
    logic                  r_hold_x_last;
    logic [LABEL_BITS-1:0] r_last_center;
    logic [LABEL_BITS-1:0] r_last_above;

    logic [LABEL_BITS-1:0] newer;
    logic [LABEL_BITS-1:0] older;
    logic [LABEL_BITS-1:0] right;

    // When the previous beat wrote the same column in the cycle of this read,
    // the memories returned stale data and the last written values are used.
    assign newer = i_cmd.fwd ? r_last_center : i_center_rdata;
    assign older = i_cmd.fwd ? r_last_above  : i_above_rdata;
    assign right = r_hold_x_last ? '0 : newer;

    assign o_we           = i_valid && i_cmd.wr;
    assign o_center_wdata = i_label;
    assign o_above_wdata  = newer;

    assign o_push        = i_valid && r_hold_valid;
    assign o_pixel_label = r_hold_me;
    assign o_last        = i_cmd.fin;
    assign o_border      = (r_hold_me != '0) &&
                           ((r_hold_left != r_hold_me) || (right != r_hold_me) ||
                            (r_hold_top != r_hold_me) || (r_hold_bot != r_hold_me));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_hold_valid <= 1'b0;
        end else if (i_valid) begin
            r_hold_valid <= i_cmd.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && i_cmd.eval) begin
            r_hold_me     <= newer;
            r_hold_left   <= i_cmd.x_first ? '0 : r_hold_me;
            r_hold_top    <= i_cmd.top_ok ? older : '0;
            r_hold_bot    <= i_label;
            r_hold_x_last <= i_cmd.x_last;
        end
        if (o_we) begin
            r_last_center <= i_label;
            r_last_above  <= newer;
        end
    end

endmodule

/* rtl/core/lbd_outq.sv */
module lbd_outq #(
    parameter int unsigned WIDTH = 26
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [WIDTH-1:0]                    i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [WIDTH-1:0]                    o_data,
    output logic [lbd_pkg::OUTQ_CNT_BITS-1:0]   o_count
);

    import lbd_pkg::*;

    localparam int unsigned PW = $clog2(OUTQ_DEPTH);

    logic [WIDTH-1:0]         r_entry [OUTQ_DEPTH];
    logic [PW-1:0]            r_wr_ptr;
    logic [PW-1:0]            r_rd_ptr;
    logic [OUTQ_CNT_BITS-1:0] r_count;
    logic                     pop;

    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + OUTQ_CNT_BITS'(i_push) - OUTQ_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* rtl/core/label_boundary_detector_core.sv */
// Four-neighbour boundary detector for a label image streamed in raster order.
// Each input beat carries a 24-bit label in tdata and a mode bit in tuser:
// mode 0 is a pixel, mode 1 a drain beat. A drain beat before the frame's last
// pixel is dropped; after it, W+1 beats are needed to flush the final row, and
// a pixel beat in that phase counts as a drain beat with its label discarded.
// Each output beat carries the border flag and the pixel's label in tdata, and
// tlast marks the frame's final pixel. Results appear W+1 input beats after
// their pixel; each output beat passes the s1 registers and the output queue.
// One beat is accepted per cycle while tready is high: the two line memories
// are read once per beat and written in the following cycle, with a bypass
// when the same column is read and written together (a width of one).
// A four-entry output queue decouples the sides; tready drops only once the
// queue and the beat in flight could fill it, so a stalled receiver backs up
// into the input after four results. Reset sets 640 x 480 and starts a new
// frame; writing either size register also restarts the frame, and must only
// be done while no results are outstanding. Line memory contents need no
// clearing, as data read from a column not yet written in the frame is unused.
module label_boundary_detector_core #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned LABEL_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [lbd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // label
    input  logic [((LABEL_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // border, pixel_label
    output logic [((LABEL_BITS+8)/8)*8-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);

    import lbd_pkg::*;

    localparam int unsigned AW      = $clog2(MAX_WIDTH);
    localparam int unsigned OUT_W   = ((LABEL_BITS + 8) / 8) * 8;
    localparam int unsigned ENTRY_W = LABEL_BITS + 2;

    logic                     accept;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     s1_valid;
    t_cmd                     s1_cmd;
    logic [AW-1:0]            s1_addr;
    logic [LABEL_BITS-1:0]    s1_label;
    logic [LABEL_BITS-1:0]    center_rdata;
    logic [LABEL_BITS-1:0]    above_rdata;
    logic                     we;
    logic [LABEL_BITS-1:0]    center_wdata;
    logic [LABEL_BITS-1:0]    above_wdata;
    logic                     push;
    logic                     border;
    logic [LABEL_BITS-1:0]    pixel_label;
    logic                     last;
    logic [ENTRY_W-1:0]       q_out;
    logic [OUTQ_CNT_BITS-1:0] q_count;
    logic [OUTQ_CNT_BITS:0]   committed;

    assign committed     = {1'b0, q_count} + (OUTQ_CNT_BITS+1)'(s1_valid);
    assign s_axis_tready = (committed < (OUTQ_CNT_BITS+1)'(OUTQ_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    lbd_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (s_axis_tuser),
        .i_label     (s_axis_tdata[LABEL_BITS-1:0]),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1_cmd    (s1_cmd),
        .o_s1_addr   (s1_addr),
        .o_s1_label  (s1_label)
    );

    lbd_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (s1_addr),
        .i_wdata (center_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (center_rdata)
    );

    lbd_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (s1_addr),
        .i_wdata (above_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (above_rdata)
    );

    lbd_eval #(
        .LABEL_BITS (LABEL_BITS)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (i_cfg_we),
        .i_valid        (s1_valid),
        .i_cmd          (s1_cmd),
        .i_label        (s1_label),
        .i_center_rdata (center_rdata),
        .i_above_rdata  (above_rdata),
        .o_we           (we),
        .o_center_wdata (center_wdata),
        .o_above_wdata  (above_wdata),
        .o_push         (push),
        .o_border       (border),
        .o_pixel_label  (pixel_label),
        .o_last         (last)
    );

    lbd_outq #(
        .WIDTH (ENTRY_W)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({last, pixel_label, border}),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (q_out),
        .o_count (q_count)
    );

    assign m_axis_tdata = OUT_W'(q_out[LABEL_BITS:0]);
    assign m_axis_tlast = q_out[ENTRY_W-1];

endmodule
